// ===== design/cmbb_pkg.sv =====
// shared types and constants of the clipped mono bitmap blit core
package cmbb_pkg;

    localparam int STORE_WORDS = 512;
    localparam int NUM_BANKS   = 2;
    localparam int BANK_DEPTH  = STORE_WORDS / NUM_BANKS;
    localparam int BANK_AW     = $clog2(BANK_DEPTH);
    localparam int WORD_W      = 32;
    localparam int BIT_W       = $clog2(WORD_W);
    localparam int WADDR_W     = $clog2(STORE_WORDS);
    localparam int NUM_LANES   = 8;
    localparam int COORD_W     = 12;
    localparam int WIDX_W      = 17;
    localparam int CNT_W       = 4;
    localparam int CFG_DATA_W  = 11;
    localparam int OUT_DEPTH   = 4;
    localparam int OUT_PTR_W   = 2;
    localparam int OUT_CNT_W   = 3;

    typedef enum logic [1:0] {
        KIND_BLIT  = 2'd0,
        KIND_READ  = 2'd1,
        KIND_WRITE = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CFG_DEST_X        = 2'd0,
        CFG_DEST_Y        = 2'd1,
        CFG_REGION_WIDTH  = 2'd2,
        CFG_REGION_HEIGHT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        t_kind         kind;
        logic [7:0]    source_byte;
        logic [8:0]    word_address;
        logic [31:0]   word_data;
    } t_in_item;

    typedef struct packed {
        logic [31:0]   read_data;
        logic          region_done;
        logic [3:0]    pixels_written;
    } t_out_item;

    typedef struct packed {
        logic               vld;
        logic               bank;
        logic [BANK_AW-1:0] waddr;
        logic [BIT_W-1:0]   bitpos;
        logic               val;
    } t_lane_res;

    typedef struct packed {
        logic               wr;
        logic [BANK_AW-1:0] addr;
        logic [WORD_W-1:0]  mask;
        logic [WORD_W-1:0]  bits;
    } t_bank_req;

endpackage

// ===== design/cmbb_ram.sv =====
// generic single write port ram with registered read
module cmbb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/cmbb_lane.sv =====
// one pixel lane: clipping and word placement of a single source bit
module cmbb_lane #(
    parameter int LANE       = 0,
    parameter int MASK_WIDTH = 256
) (
    input  logic signed [cmbb_pkg::COORD_W-1:0] i_dx0,
    input  logic [6:0]                          i_col_base,
    input  logic [9:0]                          i_width,
    input  logic [cmbb_pkg::WIDX_W-1:0]         i_dyw,
    input  logic                                i_dy_ok,
    input  logic                                i_pix,
    output cmbb_pkg::t_lane_res                 o_res
);

    localparam logic [cmbb_pkg::COORD_W-1:0] MW = cmbb_pkg::COORD_W'(MASK_WIDTH);

    logic [cmbb_pkg::COORD_W-1:0] dx;
    logic [9:0]                   col;
    logic [cmbb_pkg::WIDX_W-1:0]  widx;
    logic                         in_x;

    always_comb begin
        dx   = $unsigned(i_dx0) + cmbb_pkg::COORD_W'(LANE);
        col  = {i_col_base, 3'b000} + 10'(LANE);
        in_x = !dx[cmbb_pkg::COORD_W-1] && (dx < MW);
        widx = i_dyw + cmbb_pkg::WIDX_W'(dx[10:5]);
        o_res.vld    = i_dy_ok && in_x && (col < i_width)
                       && (widx < cmbb_pkg::WIDX_W'(cmbb_pkg::STORE_WORDS));
        o_res.bank   = widx[0];
        o_res.waddr  = widx[cmbb_pkg::WADDR_W-1:1];
        o_res.bitpos = dx[cmbb_pkg::BIT_W-1:0];
        o_res.val    = i_pix;
    end

endmodule

// ===== design/cmbb_merge.sv =====
// merges lane results and word operations into per-bank update requests
module cmbb_merge (
    input  cmbb_pkg::t_kind                                      i_kind,
    input  logic [cmbb_pkg::WADDR_W-1:0]                         i_word_address,
    input  logic [cmbb_pkg::WORD_W-1:0]                          i_word_data,
    input  cmbb_pkg::t_lane_res [cmbb_pkg::NUM_LANES-1:0]        i_lanes,
    output cmbb_pkg::t_bank_req [cmbb_pkg::NUM_BANKS-1:0]        o_req,
    output logic [cmbb_pkg::CNT_W-1:0]                           o_count,
    output logic                                                 o_rd_bank
);

    always_comb begin
        o_req     = '0;
        o_count   = '0;
        o_rd_bank = i_word_address[0];
        case (i_kind)
            cmbb_pkg::KIND_BLIT: begin
                for (int i = 0; i < cmbb_pkg::NUM_LANES; i++) begin
                    if (i_lanes[i].vld) begin
                        o_count = o_count + cmbb_pkg::CNT_W'(1);
                    end
                    for (int b = 0; b < cmbb_pkg::NUM_BANKS; b++) begin
                        if (i_lanes[i].vld && (i_lanes[i].bank == 1'(b))) begin
                            o_req[b].wr   = 1'b1;
                            o_req[b].addr = o_req[b].addr | i_lanes[i].waddr;
                            o_req[b].mask[i_lanes[i].bitpos] = 1'b1;
                            o_req[b].bits[i_lanes[i].bitpos] = i_lanes[i].val;
                        end
                    end
                end
            end
            cmbb_pkg::KIND_READ: begin
                o_req[i_word_address[0]].addr = i_word_address[cmbb_pkg::WADDR_W-1:1];
            end
            cmbb_pkg::KIND_WRITE: begin
                o_req[i_word_address[0]].wr   = 1'b1;
                o_req[i_word_address[0]].addr = i_word_address[cmbb_pkg::WADDR_W-1:1];
                o_req[i_word_address[0]].mask = '1;
                o_req[i_word_address[0]].bits = i_word_data;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== design/clipped_mono_bitmap_blit_core.sv =====
// top level of the clipped mono bitmap blit core
// Takes one transaction per clock cycle while no clearing pass runs and the queue has
// room, and returns exactly one result per transaction, in order. A result passes the
// stage 1 and stage 2 registers and waits in a four-entry output queue, so input keeps
// flowing while the consumer stalls until the queue and pipeline together are full. The
// mask store is split into even and odd word banks so that the eight pixel lanes of one
// source byte update both words they can touch with one read-modify-write per bank per
// cycle, the last write of each bank being forwarded to the next read. After reset the
// store is cleared by a pass over every bank address during which no input is taken;
// configuration writes are taken at any time and must only be issued while idle.
module clipped_mono_bitmap_blit_core #(
    parameter int MASK_WIDTH  = 256,
    parameter int MASK_HEIGHT = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  cmbb_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output cmbb_pkg::t_out_item                 o_out_item,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  cmbb_pkg::t_cfg_idx                  i_cfg_index,
    input  logic [cmbb_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int WPR = MASK_WIDTH / 32;
    localparam int CW  = cmbb_pkg::COORD_W;
    localparam int XW  = cmbb_pkg::WIDX_W;
    localparam int NB  = cmbb_pkg::NUM_BANKS;
    localparam int WW  = cmbb_pkg::WORD_W;

    // configuration and position
    logic [10:0] r_dest_x;
    logic [10:0] r_dest_y;
    logic [9:0]  r_width;
    logic [9:0]  r_height;
    logic [9:0]  r_row;
    logic [6:0]  r_bcol;

    // clearing pass
    logic                         r_clr_busy;
    logic [cmbb_pkg::BANK_AW-1:0] r_clr_addr;

    // stage 1
    logic                           r_v1;
    cmbb_pkg::t_kind                r_s1_kind;
    logic [7:0]                     r_s1_src;
    logic [cmbb_pkg::WADDR_W-1:0]   r_s1_addr;
    logic [WW-1:0]                  r_s1_data;
    logic signed [CW-1:0]           r_s1_dx0;
    logic [6:0]                     r_s1_bcol;
    logic [XW-1:0]                  r_s1_dyw;
    logic                           r_s1_dy_ok;
    logic                           r_s1_done;

    // stage 2
    logic                                  r_v2;
    cmbb_pkg::t_kind                       r_s2_kind;
    logic                                  r_s2_done;
    logic [cmbb_pkg::CNT_W-1:0]            r_s2_count;
    cmbb_pkg::t_bank_req [NB-1:0]          r_s2_req;
    logic                                  r_s2_rd_bank;

    // last write of each bank
    logic [NB-1:0]                         r_wb_vld;
    logic [NB-1:0][cmbb_pkg::BANK_AW-1:0]  r_wb_addr;
    logic [NB-1:0][WW-1:0]                 r_wb_data;

    // output queue
    cmbb_pkg::t_out_item                r_fifo [cmbb_pkg::OUT_DEPTH];
    logic [cmbb_pkg::OUT_PTR_W-1:0]     r_head;
    logic [cmbb_pkg::OUT_PTR_W-1:0]     r_tail;
    logic [cmbb_pkg::OUT_CNT_W-1:0]     r_count;

    logic                           in_acc;
    logic                           pop;
    logic [CW-1:0]                  dx0;
    logic [CW-1:0]                  dy;
    logic                           dy_ok;
    logic [XW-1:0]                  dyw;
    logic [7:0]                     stride;
    logic                           col_end;
    logic                           row_end;
    logic [cmbb_pkg::OUT_CNT_W-1:0] occ;

    cmbb_pkg::t_lane_res [cmbb_pkg::NUM_LANES-1:0] lanes;
    cmbb_pkg::t_bank_req [NB-1:0]                  req;
    logic [cmbb_pkg::CNT_W-1:0]                    cnt;
    logic                                          rd_bank;

    logic [NB-1:0][WW-1:0]                ram_q;
    logic [NB-1:0][WW-1:0]                old_w;
    logic [NB-1:0][WW-1:0]                new_w;
    logic [NB-1:0]                        upd;
    logic [NB-1:0]                        ram_we;
    logic [NB-1:0][cmbb_pkg::BANK_AW-1:0] ram_waddr;
    logic [NB-1:0][WW-1:0]                ram_wdata;
    cmbb_pkg::t_out_item                  res;

    assign o_cfg_ready = 1'b1;
    assign pop         = o_out_valid && i_out_ready;
    assign occ         = r_count + cmbb_pkg::OUT_CNT_W'(r_v1) + cmbb_pkg::OUT_CNT_W'(r_v2);
    assign o_in_ready  = !r_clr_busy && (occ < cmbb_pkg::OUT_CNT_W'(cmbb_pkg::OUT_DEPTH));
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = (r_count != '0);
    assign o_out_item  = r_fifo[r_head];

    // stage 0: position of the byte and row placement
    always_comb begin
        dx0     = {r_dest_x[10], r_dest_x} + CW'({r_bcol, 3'b000});
        dy      = {r_dest_y[10], r_dest_y} + CW'(r_row);
        dy_ok   = !dy[CW-1] && (dy < CW'(MASK_HEIGHT));
        dyw     = XW'(dy[10:0]) * XW'(WPR);
        stride  = 8'((11'(r_width) + 11'd7) >> 3);
        col_end = (8'(r_bcol) + 8'd1) >= stride;
        row_end = (11'(r_row) + 11'd1) >= 11'(r_height);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_x   <= '0;
            r_dest_y   <= '0;
            r_width    <= 10'd8;
            r_height   <= 10'd8;
            r_row      <= '0;
            r_bcol     <= '0;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_wb_vld   <= '0;
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    cmbb_pkg::CFG_DEST_X:        r_dest_x <= i_cfg_data[10:0];
                    cmbb_pkg::CFG_DEST_Y:        r_dest_y <= i_cfg_data[10:0];
                    cmbb_pkg::CFG_REGION_WIDTH:  r_width  <= i_cfg_data[9:0];
                    cmbb_pkg::CFG_REGION_HEIGHT: r_height <= i_cfg_data[9:0];
                    default: begin
                    end
                endcase
            end
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == cmbb_pkg::BANK_AW'(cmbb_pkg::BANK_DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (in_acc && (i_in_item.kind == cmbb_pkg::KIND_BLIT)) begin
                if (col_end) begin
                    r_bcol <= '0;
                    r_row  <= row_end ? '0 : r_row + 1'b1;
                end else begin
                    r_bcol <= r_bcol + 1'b1;
                end
            end
            r_v1 <= in_acc;
            r_v2 <= r_v1;
            for (int b = 0; b < NB; b++) begin
                if (upd[b]) begin
                    r_wb_vld[b] <= 1'b1;
                end
            end
            if (r_v2) begin
                r_tail <= r_tail + 1'b1;
            end
            if (pop) begin
                r_head <= r_head + 1'b1;
            end
            r_count <= r_count + cmbb_pkg::OUT_CNT_W'(r_v2) - cmbb_pkg::OUT_CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_kind  <= i_in_item.kind;
            r_s1_src   <= i_in_item.source_byte;
            r_s1_addr  <= i_in_item.word_address;
            r_s1_data  <= i_in_item.word_data;
            r_s1_dx0   <= dx0;
            r_s1_bcol  <= r_bcol;
            r_s1_dyw   <= dyw;
            r_s1_dy_ok <= dy_ok;
            r_s1_done  <= (i_in_item.kind == cmbb_pkg::KIND_BLIT) && col_end && row_end;
        end
        if (r_v1) begin
            r_s2_kind    <= r_s1_kind;
            r_s2_done    <= r_s1_done;
            r_s2_count   <= cnt;
            r_s2_req     <= req;
            r_s2_rd_bank <= rd_bank;
        end
        for (int b = 0; b < NB; b++) begin
            if (upd[b]) begin
                r_wb_addr[b] <= r_s2_req[b].addr;
                r_wb_data[b] <= new_w[b];
            end
        end
        if (r_v2) begin
            r_fifo[r_tail] <= res;
        end
    end

    // stage 1: pixel lanes and merge
    for (genvar g = 0; g < cmbb_pkg::NUM_LANES; g++) begin : g_lane
        cmbb_lane #(
            .LANE       (g),
            .MASK_WIDTH (MASK_WIDTH)
        ) u_lane (
            .i_dx0      (r_s1_dx0),
            .i_col_base (r_s1_bcol),
            .i_width    (r_width),
            .i_dyw      (r_s1_dyw),
            .i_dy_ok    (r_s1_dy_ok),
            .i_pix      (r_s1_src[cmbb_pkg::NUM_LANES-1-g]),
            .o_res      (lanes[g])
        );
    end

    cmbb_merge u_merge (
        .i_kind         (r_s1_kind),
        .i_word_address (r_s1_addr),
        .i_word_data    (r_s1_data),
        .i_lanes        (lanes),
        .o_req          (req),
        .o_count        (cnt),
        .o_rd_bank      (rd_bank)
    );

    // stage 2: read-modify-write of both banks
    for (genvar b = 0; b < NB; b++) begin : g_bank
        always_comb begin
            old_w[b] = (r_wb_vld[b] && (r_wb_addr[b] == r_s2_req[b].addr))
                       ? r_wb_data[b] : ram_q[b];
            new_w[b] = (old_w[b] & ~r_s2_req[b].mask)
                       | (r_s2_req[b].bits & r_s2_req[b].mask);
            upd[b]   = r_v2 && r_s2_req[b].wr;
            if (r_clr_busy) begin
                ram_we[b]    = 1'b1;
                ram_waddr[b] = r_clr_addr;
                ram_wdata[b] = '0;
            end else begin
                ram_we[b]    = upd[b];
                ram_waddr[b] = r_s2_req[b].addr;
                ram_wdata[b] = new_w[b];
            end
        end

        cmbb_ram #(
            .WIDTH (WW),
            .DEPTH (cmbb_pkg::BANK_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (ram_we[b]),
            .i_waddr (ram_waddr[b]),
            .i_wdata (ram_wdata[b]),
            .i_raddr (req[b].addr),
            .o_rdata (ram_q[b])
        );
    end

    always_comb begin
        res.read_data      = (r_s2_kind == cmbb_pkg::KIND_READ) ? old_w[r_s2_rd_bank] : '0;
        res.region_done    = r_s2_done;
        res.pixels_written = r_s2_count;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !pop) |-> (r_count < cmbb_pkg::OUT_CNT_W'(cmbb_pkg::OUT_DEPTH)))
        else $error("output queue overflow");

    a_pipe_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |=> r_v2)
        else $error("stage 1 transaction lost");

    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && (r_s2_kind == cmbb_pkg::KIND_BLIT)) |->
        (($countones(r_s2_req[0].mask) + $countones(r_s2_req[1].mask))
         == int'(r_s2_count)))
        else $error("pixel count differs from bank masks");

    a_clear_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_clr_busy |=> !r_clr_busy)
        else $error("clearing pass restarted");

endmodule
